// ===== rtl/stbs_pkg.sv =====
// shared types, codes and constants for the sorted table bound search block
package stbs_pkg;

   // field widths of the request and response payloads
   localparam int OP_W    = 2;
   localparam int INDEX_W = 10;
   localparam int KEY_W   = 32;
   localparam int COUNT_W = 11;
   localparam int POS_W   = 12;

   // default sizes handed down from the top level
   localparam int DEFAULT_TABLE_DEPTH = 1024;
   localparam int DEFAULT_QUEUE_DEPTH = 2;

   // request operation codes
   typedef logic [OP_W-1:0] op_type;
   localparam op_type OP_LOAD        = 2'd0;
   localparam op_type OP_LOWER_BOUND = 2'd1;
   localparam op_type OP_UPPER_BOUND = 2'd2;

   typedef logic signed [POS_W-1:0] pos_type;

   // classified command kinds held in the queue
   typedef enum logic [1:0] {
      CMD_LOAD,
      CMD_LOWER,
      CMD_UPPER
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type               kind;
      logic [INDEX_W-1:0]         entry_index;
      logic signed [KEY_W-1:0]    item_value;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   // search sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_COMPARE,
      ST_DONE
   } search_state_type;

endpackage

// ===== rtl/stbs_channels.sv =====
// request and response channel interfaces
interface stbs_req_if import stbs_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [OP_W-1:0]         operation;
   logic [INDEX_W-1:0]      entry_index;
   logic signed [KEY_W-1:0] item_value;

   modport source (output valid, output operation, output entry_index, output item_value,
                   input ready);
   modport sink   (input valid, input operation, input entry_index, input item_value,
                   output ready);
endinterface

interface stbs_rsp_if import stbs_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [POS_W-1:0] position;

   modport source (output valid, output position, input ready);
   modport sink   (input valid, input position, output ready);
endinterface

// ===== rtl/stbs_front.sv =====
// front end: accepts requests, classifies them and drops those that do nothing
module stbs_front import stbs_pkg::*; #(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
   stbs_req_if.sink     req,
   input  q_status_type q_status,
   output logic         push,
   output cmd_type      push_cmd
);

   logic         keep;
   cmd_kind_type kind;

   // decode the operation; unknown codes and loads beyond the table are dropped
   always_comb begin
      keep = 1'b0;
      kind = CMD_LOAD;
      case (req.operation)
         OP_LOAD: begin
            kind = CMD_LOAD;
            keep = (32'(req.entry_index) < TABLE_DEPTH);
         end
         OP_LOWER_BOUND: begin
            kind = CMD_LOWER;
            keep = 1'b1;
         end
         OP_UPPER_BOUND: begin
            kind = CMD_UPPER;
            keep = 1'b1;
         end
         default: begin
            kind = CMD_LOAD;
            keep = 1'b0;
         end
      endcase
   end

   // accept whenever the queue has room
   assign req.ready            = !q_status.full;
   assign push                 = req.valid && !q_status.full && keep;
   assign push_cmd.kind        = kind;
   assign push_cmd.entry_index = req.entry_index;
   assign push_cmd.item_value  = req.item_value;

endmodule

// ===== rtl/stbs_queue.sv =====
// short command queue between the front end and the search engine
module stbs_queue import stbs_pkg::*; #(
   parameter int DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  cmd_type      push_cmd,
   input  logic         pop,
   output cmd_type      pop_cmd,
   output q_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type          entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign pop_cmd      = entries_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

// ===== rtl/stbs_back.sv =====
// back end: table memory, entry count register and the halving search sequencer
module stbs_back import stbs_pkg::*; #(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_en,
   input  logic [COUNT_W-1:0] csr_write_data,
   input  q_status_type       q_status,
   output logic               pop,
   input  cmd_type            pop_cmd,
   stbs_rsp_if.source         rsp
);

   localparam int ADDR_W = $clog2(TABLE_DEPTH);

   logic [KEY_W-1:0]        value_mem [TABLE_DEPTH];
   logic [KEY_W-1:0]        rd_data_ff;

   search_state_type        state_ff, state_in;
   pos_type                 low_ff, low_in;
   pos_type                 high_ff, high_in;
   pos_type                 mid_ff, mid_in;
   logic signed [KEY_W-1:0] key_ff, key_in;
   logic                    upper_ff, upper_in;
   logic [COUNT_W-1:0]      count_ff, count_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   pos_type                 position_ff, position_in;

   logic                    mem_we, mem_re, rsp_load;
   logic                    is_query, in_range, go_right;
   pos_type                 covered, span, mid;
   logic signed [KEY_W-1:0] probe;
   logic [ADDR_W-1:0]       rd_addr, wr_addr;

   // search window arithmetic
   assign covered  = (32'(count_ff) > TABLE_DEPTH) ? POS_W'(TABLE_DEPTH)
                                                   : pos_type'({1'b0, count_ff});
   assign span     = high_ff - low_ff;
   assign mid      = low_ff + (span >>> 1);
   assign in_range = (low_ff <= high_ff);
   assign probe    = $signed(rd_data_ff);
   assign go_right = upper_ff ? (probe <= key_ff) : (probe < key_ff);
   assign is_query = (pop_cmd.kind != CMD_LOAD);
   assign rd_addr  = ADDR_W'($unsigned(mid));
   assign wr_addr  = ADDR_W'(pop_cmd.entry_index);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty && is_query) state_in = ST_READ;
         end
         ST_READ: begin
            state_in = in_range ? ST_COMPARE : ST_DONE;
         end
         ST_COMPARE: begin
            state_in = ST_READ;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp.ready) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      pop      = 1'b0;
      mem_we   = 1'b0;
      mem_re   = 1'b0;
      rsp_load = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            pop    = !q_status.empty;
            mem_we = !q_status.empty && !is_query;
         end
         ST_READ: begin
            mem_re = in_range;
         end
         ST_COMPARE: begin
            pop = 1'b0;
         end
         ST_DONE: begin
            rsp_load = !rsp_valid_ff || rsp.ready;
         end
         default: begin
            pop = 1'b0;
         end
      endcase
   end

   // search window, key and response register updates
   always_comb begin
      low_in       = low_ff;
      high_in      = high_ff;
      mid_in       = mid_ff;
      key_in       = key_ff;
      upper_in     = upper_ff;
      position_in  = position_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      count_in     = csr_write_en ? csr_write_data : count_ff;
      if (state_ff == ST_IDLE && pop && is_query) begin
         low_in   = '0;
         high_in  = covered - 1'b1;
         key_in   = pop_cmd.item_value;
         upper_in = (pop_cmd.kind == CMD_UPPER);
      end
      if (state_ff == ST_READ) begin
         mid_in = mid;
      end
      if (state_ff == ST_COMPARE) begin
         if (go_right) begin
            low_in = mid_ff + 1'b1;
         end else begin
            high_in = mid_ff - 1'b1;
         end
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         position_in  = upper_ff ? high_ff : low_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      low_ff      <= low_in;
      high_ff     <= high_in;
      mid_ff      <= mid_in;
      key_ff      <= key_in;
      upper_ff    <= upper_in;
      position_ff <= position_in;
   end

   // table memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         value_mem[wr_addr] <= pop_cmd.item_value;
      end
      if (mem_re) begin
         rd_data_ff <= value_mem[rd_addr];
      end
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.position = position_ff;

endmodule

// ===== rtl/sorted_table_bound_search_core.sv =====
// top level of the sorted table bound search block
//
// Requests arrive on req_chan (valid/ready): a load writes item_value into
// table entry entry_index and gives no response; a lower-bound query returns
// the first index whose value is at least the key (or the entry count,
// capped at the table depth, if none); an upper query returns the last index
// whose value is at most the key (or -1). Unknown operations and loads
// beyond the table are dropped. Responses leave on rsp_chan (valid/ready)
// from an output register. csr_write_en/csr_write_data set the entry count;
// write it only when idle. A load goes from the queue head into the table;
// a query runs s halving steps, at most floor(log2(count))+1, each one
// registered table read and one compare, then writes its result into the
// response register once any earlier response there has been taken; only
// then does the engine take its next command from the queue.
// A two-entry command queue lets requests be accepted while the engine
// works or while a response waits on a stalled receiver; when the queue is
// full req_chan.ready drops. Reset clears the queue, the engine state, the
// response register and the entry count; table contents are undefined
// until loaded and must not be searched before then.
module sorted_table_bound_search_core import stbs_pkg::*; #(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_en,
   input  logic [COUNT_W-1:0] csr_write_data,
   stbs_req_if.sink           req_chan,
   stbs_rsp_if.source         rsp_chan
);

   logic         push, pop;
   cmd_type      push_cmd, pop_cmd;
   q_status_type q_status;

   // request classification
   stbs_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
      .req      (req_chan),
      .q_status (q_status),
      .push     (push),
      .push_cmd (push_cmd)
   );

   // decoupling queue
   stbs_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .status   (q_status)
   );

   // table and search engine
   stbs_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .q_status       (q_status),
      .pop            (pop),
      .pop_cmd        (pop_cmd),
      .rsp            (rsp_chan)
   );

   // checks
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_status.full)
      else $error("command pushed into a full queue");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("command popped from an empty queue");

   a_position_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.position >= -12'sd1))
      else $error("response position below -1");

   a_quiet_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_chan.valid)
      else $error("response valid straight after reset");

endmodule

// ===== tb/sorted_table_bound_search_core_tb.sv =====
// self-checking testbench for the sorted table bound search core
module sorted_table_bound_search_core_tb;
   import stbs_pkg::*;

   localparam int TABLE_DEPTH = DEFAULT_TABLE_DEPTH;
   localparam int MAX_GAP     = 16;
   localparam int IDLE_CYCLES = 100;
   localparam int RANDOM_ITEMS = 1000;
   localparam int PRINT_CAP   = 40;
   localparam op_type OP_UNUSED = 2'd3;

   logic               clock;
   logic               reset;
   logic               csr_write_en;
   logic [COUNT_W-1:0] csr_write_data;

   stbs_req_if req_chan ();
   stbs_rsp_if rsp_chan ();

   sorted_table_bound_search_core uut (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan)
   );

   // predictor state: table contents and the entry count
   logic signed [KEY_W-1:0] stored_values [TABLE_DEPTH];
   logic [COUNT_W-1:0]      entry_count_model;
   pos_type                 expected_positions [$];

   int  mismatches;
   int  random_items;
   int  loads_sent;
   int  queries_sent;
   int  responses_seen;
   int  count_settings;
   int  stall_left;
   bit  send_idle;
   bit  take_idle;

   // clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // run limit
   initial begin
      #15000000;
      $display("CHECKS FAILED");
      $finish;
   end

   task automatic report_mismatch(input string what, input pos_type got, input pos_type want);
      if (mismatches < PRINT_CAP)
         $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
      mismatches++;
   endtask

   // binary search as the block performs it, on the mirrored table
   function automatic pos_type predict_bound(input logic signed [KEY_W-1:0] key,
                                             input bit at_most);
      int lo;
      int hi;
      int mid;
      logic signed [KEY_W-1:0] probe;
      bit go_right;
      pos_type found;
      lo = 0;
      hi = (entry_count_model > TABLE_DEPTH) ? TABLE_DEPTH - 1 : int'(entry_count_model) - 1;
      while (lo <= hi) begin
         mid = lo + (hi - lo) / 2;
         probe = stored_values[mid];
         go_right = at_most ? (probe <= key) : (probe < key);
         if (go_right) begin
            lo = mid + 1;
         end else begin
            hi = mid - 1;
         end
      end
      found = at_most ? hi[POS_W-1:0] : lo[POS_W-1:0];
      return found;
   endfunction

   // response side: random stalls and the comparison against the oldest expectation
   task automatic check_response(input pos_type got);
      pos_type want;
      responses_seen++;
      if (expected_positions.size() == 0) begin
         report_mismatch("unexpected response position", got, got);
      end else begin
         want = expected_positions.pop_front();
         if (got !== want)
            report_mismatch("position", got, want);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_left = 0;
      end else if (rsp_chan.valid && rsp_chan.ready) begin
         check_response(rsp_chan.position);
         stall_left = take_idle ? $urandom_range(0, MAX_GAP) : 0;
         rsp_chan.ready <= (stall_left == 0);
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_chan.ready <= (stall_left == 0);
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // send one request and update the predictor when it is accepted
   task automatic send_request(input op_type op, input logic [INDEX_W-1:0] idx,
                               input logic signed [KEY_W-1:0] value);
      int gap;
      gap = send_idle ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.operation   <= op;
      req_chan.entry_index <= idx;
      req_chan.item_value  <= value;
      do @(posedge clock); while (!req_chan.ready);
      case (op)
         OP_LOAD: begin
            stored_values[idx] = value;
            loads_sent++;
         end
         OP_LOWER_BOUND: begin
            expected_positions.push_back(predict_bound(value, 1'b0));
            queries_sent++;
         end
         OP_UPPER_BOUND: begin
            expected_positions.push_back(predict_bound(value, 1'b1));
            queries_sent++;
         end
         default: ;
      endcase
   endtask

   // drain everything outstanding, including work that gives no response
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      while (expected_positions.size() != 0) @(posedge clock);
      repeat (IDLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_entry_count(input logic [COUNT_W-1:0] count);
      wait_idle();
      csr_write_en   <= 1'b1;
      csr_write_data <= count;
      @(posedge clock);
      entry_count_model = count;
      csr_write_en <= 1'b0;
      count_settings++;
   endtask

   task automatic query_both(input logic signed [KEY_W-1:0] key);
      send_request(OP_LOWER_BOUND, INDEX_W'($urandom_range(0, TABLE_DEPTH - 1)), key);
      send_request(OP_UPPER_BOUND, INDEX_W'($urandom_range(0, TABLE_DEPTH - 1)), key);
   endtask

   // key near a stored entry, at an extreme, or anywhere
   function automatic logic signed [KEY_W-1:0] pick_key();
      int covered;
      int slot;
      covered = (entry_count_model > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_count_model);
      slot = (covered > 0) ? $urandom_range(0, covered - 1) : $urandom_range(0, TABLE_DEPTH - 1);
      case ($urandom_range(0, 6))
         0, 1:    return stored_values[slot] + $signed($urandom_range(0, 2)) - 1;
         2:       return stored_values[slot];
         3:       return {1'b1, {(KEY_W-1){1'b0}}};
         4:       return {1'b0, {(KEY_W-1){1'b1}}};
         default: return $urandom;
      endcase
   endfunction

   // non-decreasing run starting at entry 0, saturating at the top value
   task automatic load_sorted_run(input int n, input int unsigned step_max);
      longint acc;
      if ($urandom_range(0, 3) == 0)
         acc = -64'sd2147483648;
      else
         acc = longint'($signed($urandom));
      for (int i = 0; i < n; i++) begin
         acc += $urandom_range(0, step_max);
         if (acc > 64'sd2147483647)
            acc = 64'sd2147483647;
         send_request(OP_LOAD, i[INDEX_W-1:0], acc[KEY_W-1:0]);
      end
   endtask

   // empty table: lower bound is 0, upper bound is -1, unknown op is dropped
   task automatic test_empty_table();
      set_entry_count('0);
      query_both({1'b1, {(KEY_W-1){1'b0}}});
      query_both({1'b0, {(KEY_W-1){1'b1}}});
      send_request(OP_UNUSED, INDEX_W'($urandom_range(0, TABLE_DEPTH - 1)), $urandom);
   endtask

   // a few sorted entries with duplicates and both extreme values
   task automatic test_small_sorted_table();
      send_request(OP_LOAD, 0, {1'b1, {(KEY_W-1){1'b0}}});
      send_request(OP_LOAD, 1, -5);
      send_request(OP_LOAD, 2, 0);
      send_request(OP_LOAD, 3, 0);
      send_request(OP_LOAD, 4, 7);
      send_request(OP_LOAD, 5, {1'b0, {(KEY_W-1){1'b1}}});
      send_request(OP_LOAD, INDEX_W'(TABLE_DEPTH - 1), 32'sd12345);
      set_entry_count(6);
      query_both({1'b1, {(KEY_W-1){1'b0}}});
      query_both(0);
      query_both(1);
      query_both({1'b0, {(KEY_W-1){1'b1}}});
      send_request(OP_UNUSED, 0, 32'sd99);
   endtask

   // every entry written so that any count can be searched from here on
   task automatic test_full_table();
      load_sorted_run(TABLE_DEPTH, 32'h0080_0000);
      set_entry_count(COUNT_W'(TABLE_DEPTH));
      repeat (8) query_both(pick_key());
   endtask

   // count at its maximum and just above the table size, both saturated, and a single entry
   task automatic test_count_extremes();
      set_entry_count('1);
      repeat (4) query_both(pick_key());
      set_entry_count(COUNT_W'(TABLE_DEPTH + 1));
      repeat (2) query_both(pick_key());
      set_entry_count(1);
      query_both(stored_values[0]);
      query_both(pick_key());
   endtask

   // phases: set a count, mostly reload a sorted run, then query with some noise
   task automatic test_random_phases();
      int covered;
      int n_queries;
      int unsigned step_max;
      while (random_items < RANDOM_ITEMS) begin
         send_idle = ($urandom_range(0, 3) != 0);
         take_idle = ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 9))
            7:       set_entry_count(COUNT_W'(TABLE_DEPTH));
            8:       set_entry_count(COUNT_W'($urandom_range(41, TABLE_DEPTH - 1)));
            9:       set_entry_count(COUNT_W'($urandom_range(TABLE_DEPTH + 1, 2047)));
            default: set_entry_count(COUNT_W'($urandom_range(0, 40)));
         endcase
         covered = (entry_count_model > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_count_model);
         if (covered <= 40) begin
            case ($urandom_range(0, 9))
               0: begin
                  // unsorted content
                  for (int i = 0; i < covered; i++)
                     send_request(OP_LOAD, i[INDEX_W-1:0], $urandom);
               end
               default: begin
                  case ($urandom_range(0, 2))
                     0:       step_max = 2;
                     1:       step_max = 1000;
                     default: step_max = 32'h1000_0000;
                  endcase
                  load_sorted_run(covered, step_max);
               end
            endcase
            random_items += covered;
         end
         n_queries = $urandom_range(4, 16);
         for (int q = 0; q < n_queries; q++) begin
            case ($urandom_range(0, 19))
               0: send_request(OP_UNUSED, INDEX_W'($urandom_range(0, TABLE_DEPTH - 1)),
                               $urandom);
               1: begin
                  send_request(OP_LOAD, INDEX_W'($urandom_range(0, TABLE_DEPTH - 1)),
                               $urandom);
                  random_items++;
               end
               default: begin
                  send_request($urandom_range(0, 1) ? OP_LOWER_BOUND : OP_UPPER_BOUND,
                               INDEX_W'($urandom_range(0, TABLE_DEPTH - 1)), pick_key());
                  random_items++;
               end
            endcase
         end
      end
   endtask

   initial begin
      mismatches     = 0;
      random_items   = 0;
      loads_sent     = 0;
      queries_sent   = 0;
      responses_seen = 0;
      count_settings = 0;
      send_idle      = 1'b1;
      take_idle      = 1'b1;
      entry_count_model = '0;
      for (int i = 0; i < TABLE_DEPTH; i++)
         stored_values[i] = '0;
      reset                <= 1'b1;
      csr_write_en         <= 1'b0;
      csr_write_data       <= '0;
      req_chan.valid       <= 1'b0;
      req_chan.operation   <= OP_LOAD;
      req_chan.entry_index <= '0;
      req_chan.item_value  <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_empty_table();
      test_small_sorted_table();
      test_full_table();
      test_count_extremes();
      test_random_phases();

      wait_idle();
      $display("covered %0d loads and %0d bound queries over %0d entry count settings",
               loads_sent, queries_sent, count_settings);
      $display("%0d responses checked, %0d mismatches", responses_seen, mismatches);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
